/* rtl/core/dmsp_pkg.sv */
package dmsp_pkg;

   // Magnitude width of the speed numerator: |delta| <= 2^32, times 1152000 < 2^21.
   localparam int unsigned NUM_W = 53;

   // 4.5 cm circumference in thousandths, scaled to Q8.8: 4500 * 256.
   localparam logic [21:0] CIRC_MILLI_Q8 = 22'd1152000;

   localparam int NEAR_COUNTS = 500;

   // Shared multiplier operand and product widths.
   localparam int unsigned MUL_A_W = 49;
   localparam int unsigned MUL_B_W = 22;
   localparam int unsigned PROD_W  = 64;

   typedef enum logic [3:0] {
      REG_TARGET_SPEED    = 4'd0,
      REG_TARGET_POSITION = 4'd1,
      REG_SPEED_KP        = 4'd2,
      REG_SPEED_KD        = 4'd3,
      REG_POS_KP          = 4'd4,
      REG_POS_KI          = 4'd5,
      REG_POS_KD          = 4'd6,
      REG_MAX_DRIVE       = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] target_speed;
      logic [31:0] target_position;
      logic [15:0] speed_kp;
      logic [15:0] speed_kd;
      logic [15:0] pos_kp;
      logic [15:0] pos_ki;
      logic [15:0] pos_kd;
      logic [7:0]  max_drive;
   } cfg_type;

endpackage

/* rtl/core/dmsp_csr.sv */
module dmsp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output dmsp_pkg::cfg_type cfg
);

   dmsp_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed    <= 16'd3840;
         cfg_ff.target_position <= 32'd5000;
         cfg_ff.speed_kp        <= 16'd384;
         cfg_ff.speed_kd        <= 16'd13;
         cfg_ff.pos_kp          <= 16'd512;
         cfg_ff.pos_ki          <= 16'd5;
         cfg_ff.pos_kd          <= 16'd26;
         cfg_ff.max_drive       <= 8'd180;
      end else if (csr_valid && csr_ready) begin
         unique case (dmsp_pkg::reg_index_type'(csr_index))
            dmsp_pkg::REG_TARGET_SPEED:    cfg_ff.target_speed    <= csr_wdata[15:0];
            dmsp_pkg::REG_TARGET_POSITION: cfg_ff.target_position <= csr_wdata;
            dmsp_pkg::REG_SPEED_KP:        cfg_ff.speed_kp        <= csr_wdata[15:0];
            dmsp_pkg::REG_SPEED_KD:        cfg_ff.speed_kd        <= csr_wdata[15:0];
            dmsp_pkg::REG_POS_KP:          cfg_ff.pos_kp          <= csr_wdata[15:0];
            dmsp_pkg::REG_POS_KI:          cfg_ff.pos_ki          <= csr_wdata[15:0];
            dmsp_pkg::REG_POS_KD:          cfg_ff.pos_kd          <= csr_wdata[15:0];
            dmsp_pkg::REG_MAX_DRIVE:       cfg_ff.max_drive       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/dmsp_mul.sv */
module dmsp_mul (
   input  logic                                 clock,
   input  logic signed [dmsp_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [dmsp_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [dmsp_pkg::PROD_W-1:0]  prod
);

   localparam int unsigned FULL_W = dmsp_pkg::MUL_A_W + dmsp_pkg::MUL_B_W;

   logic signed [FULL_W-1:0]           full;
   logic signed [dmsp_pkg::PROD_W-1:0] prod_ff;

   // Every product the sequencer asks for fits in the low PROD_W bits.
   assign full = FULL_W'(mul_a) * FULL_W'(mul_b);
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= $signed(full[dmsp_pkg::PROD_W-1:0]);
   end

endmodule

/* rtl/core/dmsp_div.sv */
module dmsp_div #(
   parameter int unsigned NUM_W = 53,
   parameter int unsigned DEN_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_diff;
   logic             fits;

   assign trial      = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign fits       = trial >= {1'b0, divisor};
   assign quotient   = quo_ff;
   assign done       = done_ff;

   // Restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

/* rtl/core/dual_motor_speed_position_pid_core.sv */
// Two-motor speed/position controller. Each accepted item is one control tick: both encoder
// counts and the elapsed milliseconds. Speed is estimated per motor and a PD law runs on the
// speed error; when either motor is within 500 counts of target_position, both motors switch
// to a PID law on the position error. Drives come out as a magnitude clamped to max_drive and
// a direction bit. One item is worked at a time on a shared multiplier and a radix-2 divider;
// the next item is taken only once the result has moved to the output register. The speed
// division runs for each motor in turn. A finished result waits in the output register while
// the next item is accepted. Registers are written through the csr port only while no item is
// in flight: the user must keep to this, and the block itself does not enforce it.
module dual_motor_speed_position_pid_core #(
   parameter int unsigned COUNTS_PER_REV = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_position_a,
   input  logic signed [31:0] req_position_b,
   input  logic [15:0]        req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_drive_a,
   output logic               rsp_forward_a,
   output logic [7:0]         rsp_drive_b,
   output logic               rsp_forward_b,
   output logic               rsp_position_mode,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int unsigned DEN_W  = $clog2(64'(COUNTS_PER_REV) * 64'd65535 + 64'd1);
   localparam int unsigned NUM_W  = dmsp_pkg::NUM_W;
   localparam int unsigned PROD_W = dmsp_pkg::PROD_W;

   localparam logic signed [32:0] NEAR33   = 33'(dmsp_pkg::NEAR_COUNTS);
   localparam logic signed [33:0] S32_MAX  = 34'sd2147483647;
   localparam logic signed [33:0] S32_MIN  = -34'sd2147483648;
   localparam logic signed [48:0] SUM_MAX  = 49'sd140737488355327;
   localparam logic signed [48:0] SUM_MIN  = -49'sd140737488355328;
   localparam logic signed [63:0] TERM_LIM = 64'sd2305843009213693952;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DELTA,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_SPD,
      ST_SERR,
      ST_SKP,
      ST_SKD,
      ST_SACC,
      ST_PERR,
      ST_PKP,
      ST_PKD,
      ST_PKI,
      ST_PACC,
      ST_FQ,
      ST_FCLAMP,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

   dmsp_pkg::cfg_type cfg;

   state_type          state_ff, state_in;
   logic               m_ff, m_in;
   logic               near_ff, near_in;
   logic signed [31:0] pos_ff[2], pos_in[2];
   logic [DEN_W-1:0]   den_ff, den_in;
   logic signed [31:0] last_count_ff[2], last_count_in[2];
   logic signed [31:0] last_serr_ff[2], last_serr_in[2];
   logic signed [31:0] last_perr_ff[2], last_perr_in[2];
   logic signed [47:0] esum_ff[2], esum_in[2];
   logic               neg_ff, neg_in;
   logic signed [31:0] spd_ff, spd_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [32:0] der_ff, der_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] law_ff[2], law_in[2];
   logic signed [63:0] q_ff, q_in;
   logic [7:0]         drive_ff[2], drive_in[2];
   logic               fwd_ff[2], fwd_in[2];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_drive_a_ff, rsp_drive_a_in;
   logic [7:0]         rsp_drive_b_ff, rsp_drive_b_in;
   logic               rsp_forward_a_ff, rsp_forward_a_in;
   logic               rsp_forward_b_ff, rsp_forward_b_in;
   logic               rsp_mode_ff, rsp_mode_in;

   logic signed [dmsp_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dmsp_pkg::MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]            prod;
   logic [PROD_W-1:0]                   prod_abs;
   logic                                div_start;
   logic [NUM_W-1:0]                    quotient;
   logic                                div_done;

   logic signed [31:0] tp;
   logic signed [31:0] pos_cur;
   logic signed [32:0] delta;
   logic signed [32:0] near_d_a, near_d_b;
   logic               near_new;
   logic [15:0]        ms_eff;
   logic [DEN_W-1:0]   den_new;
   logic signed [33:0] sdiff;
   logic signed [32:0] pdiff;
   logic signed [32:0] serr_der, perr_der;
   logic signed [48:0] esum_add;
   logic signed [47:0] esum_sat;
   logic signed [63:0] term_clamped;
   logic signed [63:0] fin_law, fin_q8, fin_q16;
   logic signed [63:0] lim;
   logic               accept;

   dmsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmsp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   dmsp_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[NUM_W-1:0]),
      .divisor  (den_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign tp       = $signed(cfg.target_position);
   assign pos_cur  = pos_ff[m_ff];
   assign delta    = 33'(pos_cur) - 33'(last_count_ff[m_ff]);
   assign near_d_a = 33'(tp) - 33'(req_position_a);
   assign near_d_b = 33'(tp) - 33'(req_position_b);
   assign near_new = ((near_d_a > -NEAR33) && (near_d_a < NEAR33)) ||
                     ((near_d_b > -NEAR33) && (near_d_b < NEAR33));
   assign ms_eff   = (req_elapsed_ms == 16'd0) ? 16'd1 : req_elapsed_ms;
   assign den_new  = DEN_W'(64'(ms_eff) * 64'(COUNTS_PER_REV));

   assign prod_abs = prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
   assign sdiff    = $signed({18'd0, cfg.target_speed}) - 34'(spd_ff);
   assign pdiff    = 33'(tp) - 33'(pos_cur);
   assign serr_der = 33'(err_ff) - 33'(last_serr_ff[m_ff]);
   assign perr_der = 33'(err_ff) - 33'(last_perr_ff[m_ff]);
   assign esum_add = 49'(esum_ff[m_ff]) + 49'(err_ff);
   assign esum_sat = (esum_add > SUM_MAX) ? SUM_MAX[47:0] :
                     (esum_add < SUM_MIN) ? SUM_MIN[47:0] : $signed(esum_add[47:0]);
   assign term_clamped = (prod > TERM_LIM) ? TERM_LIM :
                         (prod < -TERM_LIM) ? -TERM_LIM : prod;

   // Truncate toward zero: bias negative values before the arithmetic shift.
   assign fin_law = law_ff[m_ff];
   assign fin_q8  = (fin_law + (fin_law < 0 ? 64'sd255 : 64'sd0)) >>> 8;
   assign fin_q16 = (fin_law + (fin_law < 0 ? 64'sd65535 : 64'sd0)) >>> 16;
   assign lim     = $signed({56'd0, cfg.max_drive});

   always_comb begin
      state_in         = state_ff;
      m_in             = m_ff;
      near_in          = near_ff;
      pos_in           = pos_ff;
      den_in           = den_ff;
      last_count_in    = last_count_ff;
      last_serr_in     = last_serr_ff;
      last_perr_in     = last_perr_ff;
      esum_in          = esum_ff;
      neg_in           = neg_ff;
      spd_in           = spd_ff;
      err_in           = err_ff;
      der_in           = der_ff;
      sum_in           = sum_ff;
      acc_in           = acc_ff;
      law_in           = law_ff;
      q_in             = q_ff;
      drive_in         = drive_ff;
      fwd_in           = fwd_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_drive_a_in   = rsp_drive_a_ff;
      rsp_drive_b_in   = rsp_drive_b_ff;
      rsp_forward_a_in = rsp_forward_a_ff;
      rsp_forward_b_in = rsp_forward_b_ff;
      rsp_mode_in      = rsp_mode_ff;
      mul_a            = '0;
      mul_b            = '0;
      div_start        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in[0] = req_position_a;
               pos_in[1] = req_position_b;
               den_in    = den_new;
               near_in   = near_new;
               m_in      = 1'b0;
               state_in  = ST_DELTA;
            end
         end
         ST_DELTA: begin
            mul_a                = 49'(delta);
            mul_b                = $signed(dmsp_pkg::CIRC_MILLI_Q8);
            last_count_in[m_ff]  = pos_cur;
            state_in             = ST_DIVGO;
         end
         ST_DIVGO: begin
            neg_in    = prod[PROD_W-1];
            div_start = 1'b1;
            state_in  = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               state_in = ST_SPD;
            end
         end
         ST_SPD: begin
            if (quotient[NUM_W-1:31] != '0) begin
               spd_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               spd_in = neg_ff ? $signed(32'd0 - quotient[31:0]) : $signed(quotient[31:0]);
            end
            state_in = ST_SERR;
         end
         ST_SERR: begin
            err_in   = sat32(sdiff);
            state_in = ST_SKP;
         end
         ST_SKP: begin
            mul_a              = 49'(err_ff);
            mul_b              = $signed({6'd0, cfg.speed_kp});
            der_in             = serr_der;
            last_serr_in[m_ff] = err_ff;
            state_in           = ST_SKD;
         end
         ST_SKD: begin
            mul_a    = 49'(der_ff);
            mul_b    = $signed({6'd0, cfg.speed_kd});
            acc_in   = prod;
            state_in = ST_SACC;
         end
         ST_SACC: begin
            law_in[m_ff] = acc_ff + prod;
            if (!m_ff) begin
               m_in     = 1'b1;
               state_in = ST_DELTA;
            end else begin
               m_in     = 1'b0;
               state_in = near_ff ? ST_PERR : ST_FQ;
            end
         end
         ST_PERR: begin
            err_in   = sat32(34'(pdiff));
            state_in = ST_PKP;
         end
         ST_PKP: begin
            mul_a              = 49'(err_ff);
            mul_b              = $signed({6'd0, cfg.pos_kp});
            der_in             = perr_der;
            last_perr_in[m_ff] = err_ff;
            sum_in             = esum_sat;
            esum_in[m_ff]      = esum_sat;
            state_in           = ST_PKD;
         end
         ST_PKD: begin
            mul_a    = 49'(der_ff);
            mul_b    = $signed({6'd0, cfg.pos_kd});
            acc_in   = prod;
            state_in = ST_PKI;
         end
         ST_PKI: begin
            mul_a    = 49'(sum_ff);
            mul_b    = $signed({6'd0, cfg.pos_ki});
            acc_in   = acc_ff + prod;
            state_in = ST_PACC;
         end
         ST_PACC: begin
            law_in[m_ff] = acc_ff + term_clamped;
            if (!m_ff) begin
               m_in     = 1'b1;
               state_in = ST_PERR;
            end else begin
               m_in     = 1'b0;
               state_in = ST_FQ;
            end
         end
         ST_FQ: begin
            q_in     = near_ff ? fin_q8 : fin_q16;
            state_in = ST_FCLAMP;
         end
         ST_FCLAMP: begin
            if ((q_ff > lim) || (q_ff < -lim)) begin
               drive_in[m_ff] = cfg.max_drive;
            end else begin
               drive_in[m_ff] = q_ff[63] ? (~q_ff[7:0] + 8'd1) : q_ff[7:0];
            end
            fwd_in[m_ff] = (fin_law > 0);
            if (!m_ff) begin
               m_in     = 1'b1;
               state_in = ST_FQ;
            end else begin
               m_in     = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold the finished item until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_drive_a_in   = drive_ff[0];
               rsp_forward_a_in = fwd_ff[0];
               rsp_drive_b_in   = drive_ff[1];
               rsp_forward_b_in = fwd_ff[1];
               rsp_mode_in      = near_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      den_ff           <= den_in;
      near_ff          <= near_in;
      neg_ff           <= neg_in;
      spd_ff           <= spd_in;
      err_ff           <= err_in;
      der_ff           <= der_in;
      sum_ff           <= sum_in;
      acc_ff           <= acc_in;
      law_ff           <= law_in;
      q_ff             <= q_in;
      drive_ff         <= drive_in;
      fwd_ff           <= fwd_in;
      rsp_drive_a_ff   <= rsp_drive_a_in;
      rsp_drive_b_ff   <= rsp_drive_b_in;
      rsp_forward_a_ff <= rsp_forward_a_in;
      rsp_forward_b_ff <= rsp_forward_b_in;
      rsp_mode_ff      <= rsp_mode_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         m_ff          <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_count_ff <= '{default: '0};
         last_serr_ff  <= '{default: '0};
         last_perr_ff  <= '{default: '0};
         esum_ff       <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         m_ff          <= m_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_count_ff <= last_count_in;
         last_serr_ff  <= last_serr_in;
         last_perr_ff  <= last_perr_in;
         esum_ff       <= esum_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_a       = rsp_drive_a_ff;
   assign rsp_forward_a     = rsp_forward_a_ff;
   assign rsp_drive_b       = rsp_drive_b_ff;
   assign rsp_forward_b     = rsp_forward_b_ff;
   assign rsp_position_mode = rsp_mode_ff;

endmodule

/* rtl/core/dmsp_checker.sv */
module dmsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_drive_a,
   input logic       rsp_forward_a,
   input logic [7:0] rsp_drive_b,
   input logic       rsp_forward_b,
   input logic       rsp_position_mode
);

   // A stalled item stays on the output unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_a) &&
         $stable(rsp_forward_a) && $stable(rsp_drive_b) && $stable(rsp_forward_b) &&
         $stable(rsp_position_mode))
      else $error("result item changed while stalled");

   // An accepted item keeps the input side busy while it is worked.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after item accepted");

   // A new result is posted only as the sequencer returns to idle.
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result posted while input still busy");

   // A freshly accepted item cannot finish at once.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared too soon after item accepted");

endmodule

bind dual_motor_speed_position_pid_core dmsp_checker u_dmsp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_drive_a       (rsp_drive_a),
   .rsp_forward_a     (rsp_forward_a),
   .rsp_drive_b       (rsp_drive_b),
   .rsp_forward_b     (rsp_forward_b),
   .rsp_position_mode (rsp_position_mode)
);

/* tb/dual_motor_speed_position_pid_core_tb.sv */
`timescale 1ns / 1ps

module dual_motor_speed_position_pid_core_tb;

   localparam longint COUNTS_PER_REV = 1024;
   localparam longint WHEEL_MILLI_Q8 = 1152000;
   localparam longint NEAR_BAND = 500;
   localparam longint SUM_HI = 64'sd140737488355327;
   localparam longint SUM_LO = -64'sd140737488355328;
   localparam longint ITERM_LIM = 64'sd2305843009213693952;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh80000000;
   localparam logic [3:0] REG_UNMAPPED = 4'd13;
   localparam int SETTLE_CYCLES = 200;
   localparam int PRINT_CAP = 200;

   typedef struct {
      logic signed [31:0] position_a;
      logic signed [31:0] position_b;
      logic [15:0]        elapsed_ms;
   } tick_type;

   typedef struct {
      logic [7:0] drive_a;
      logic       forward_a;
      logic [7:0] drive_b;
      logic       forward_b;
      logic       position_mode;
   } drive_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_position_a = '0;
   logic signed [31:0] req_position_b = '0;
   logic [15:0]        req_elapsed_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_drive_a;
   logic               rsp_forward_a;
   logic [7:0]         rsp_drive_b;
   logic               rsp_forward_b;
   logic               rsp_position_mode;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   dual_motor_speed_position_pid_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_position_a    (req_position_a),
      .req_position_b    (req_position_b),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_a       (rsp_drive_a),
      .rsp_forward_a     (rsp_forward_a),
      .rsp_drive_b       (rsp_drive_b),
      .rsp_forward_b     (rsp_forward_b),
      .rsp_position_mode (rsp_position_mode),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // controller settings as last written
   logic [15:0]        target_speed_q = 16'd3840;
   logic signed [31:0] target_position_q = 32'sd5000;
   logic [15:0]        speed_kp_q = 16'd384;
   logic [15:0]        speed_kd_q = 16'd13;
   logic [15:0]        pos_kp_q = 16'd512;
   logic [15:0]        pos_ki_q = 16'd5;
   logic [15:0]        pos_kd_q = 16'd26;
   logic [7:0]         max_drive_q = 8'd180;

   // per-motor controller history
   logic signed [31:0] last_count_q [2] = '{default: '0};
   logic signed [31:0] last_speed_err_q [2] = '{default: '0};
   logic signed [31:0] last_pos_err_q [2] = '{default: '0};
   logic signed [47:0] error_sum_q [2] = '{default: '0};

   tick_type    tick_queue [$];
   drive_type   drive_expect_q [$];
   tick_type    tick_on_bus;
   int unsigned send_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   logic        long_hold_done = 1'b0;
   int unsigned ticks_accepted = 0;
   int unsigned fault_count = 0;
   logic signed [31:0] trk_a = '0;
   logic signed [31:0] trk_b = '0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [7:0] drive_level(longint law, longint divisor, longint lim);
      longint q;
      q = clip(law / divisor, -lim, lim);
      return 8'((q < 0) ? -q : q);
   endfunction

   // One control tick: speed PD on both motors, position PID when either is near target.
   function automatic drive_type control_tick(tick_type t);
      longint    ms, den, pos, delta, spd, err, der, isum, iterm, divisor;
      longint    tspd, tpos, skp, skd, pkp, pki, pkd, lim;
      longint    law [2];
      logic      near;
      int        m;
      drive_type r;
      tspd = target_speed_q;
      tpos = target_position_q;
      skp = speed_kp_q;
      skd = speed_kd_q;
      pkp = pos_kp_q;
      pki = pos_ki_q;
      pkd = pos_kd_q;
      lim = max_drive_q;
      ms = t.elapsed_ms;
      if (ms == 0) ms = 1;
      den = COUNTS_PER_REV * ms;
      near = 1'b0;
      divisor = 65536;
      for (m = 0; m < 2; m++) begin
         pos = (m == 0) ? t.position_a : t.position_b;
         delta = pos - last_count_q[m];
         last_count_q[m] = 32'(pos);
         spd = clip(delta * WHEEL_MILLI_Q8 / den, WORD_MIN, WORD_MAX);
         err = clip(tspd - spd, WORD_MIN, WORD_MAX);
         der = err - last_speed_err_q[m];
         last_speed_err_q[m] = 32'(err);
         law[m] = skp * err + skd * der;
         if (tpos - pos > -NEAR_BAND && tpos - pos < NEAR_BAND) near = 1'b1;
      end
      if (near) begin
         divisor = 256;
         for (m = 0; m < 2; m++) begin
            pos = (m == 0) ? t.position_a : t.position_b;
            err = clip(tpos - pos, WORD_MIN, WORD_MAX);
            der = err - last_pos_err_q[m];
            last_pos_err_q[m] = 32'(err);
            isum = clip(error_sum_q[m] + err, SUM_LO, SUM_HI);
            error_sum_q[m] = 48'(isum);
            iterm = clip(pki * isum, -ITERM_LIM, ITERM_LIM);
            law[m] = iterm + pkp * err + pkd * der;
         end
      end
      r.drive_a = drive_level(law[0], divisor, lim);
      r.forward_a = law[0] > 0;
      r.drive_b = drive_level(law[1], divisor, lim);
      r.forward_b = law[1] > 0;
      r.position_mode = near;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(4))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return '0;
         3: return -1;
         default: return target_position_q;
      endcase
   endfunction

   // Mostly smooth encoder walks that wander in and out of the position band.
   function automatic tick_type make_tick();
      tick_type    t;
      int unsigned kind;
      kind = $urandom_range(99);
      t.elapsed_ms = 16'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 40));
      if (kind < 65) begin
         if ($urandom_range(11) == 0) begin
            trk_a = target_position_q + (int'($urandom_range(0, 3000)) - 1500);
            trk_b = target_position_q + (int'($urandom_range(0, 3000)) - 1500);
         end else if ($urandom_range(29) == 0) begin
            trk_a = $urandom();
            trk_b = $urandom();
         end
         trk_a = trk_a + (int'($urandom_range(0, 800)) - 400);
         trk_b = trk_b + (int'($urandom_range(0, 800)) - 400);
         t.position_a = trk_a;
         t.position_b = trk_b;
      end else if (kind < 80) begin
         // straddle the edge of the position band
         t.position_a = target_position_q + (int'($urandom_range(0, 20)) - 10)
                        + ($urandom_range(1) ? 500 : -500);
         t.position_b = target_position_q + int'($urandom_range(0, 100000)) + 1000;
      end else if (kind < 95) begin
         t.position_a = $urandom();
         t.position_b = $urandom();
      end else begin
         t.position_a = pick_extreme();
         t.position_b = pick_extreme();
      end
      return t;
   endfunction

   task automatic queue_tick(input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic [15:0] ms);
      tick_type t;
      t.position_a = a;
      t.position_b = b;
      t.elapsed_ms = ms;
      tick_queue.push_back(t);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         dmsp_pkg::REG_TARGET_SPEED:    target_speed_q = data[15:0];
         dmsp_pkg::REG_TARGET_POSITION: target_position_q = data;
         dmsp_pkg::REG_SPEED_KP:        speed_kp_q = data[15:0];
         dmsp_pkg::REG_SPEED_KD:        speed_kd_q = data[15:0];
         dmsp_pkg::REG_POS_KP:          pos_kp_q = data[15:0];
         dmsp_pkg::REG_POS_KI:          pos_ki_q = data[15:0];
         dmsp_pkg::REG_POS_KD:          pos_kd_q = data[15:0];
         dmsp_pkg::REG_MAX_DRIVE:       max_drive_q = data[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (tick_queue.size() != 0 || req_valid || drive_expect_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      return ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 1024);
   endfunction

   task automatic randomize_settings();
      write_reg(dmsp_pkg::REG_TARGET_SPEED,
                ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 6000));
      write_reg(dmsp_pkg::REG_TARGET_POSITION,
                ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 400000) - 200000);
      write_reg(dmsp_pkg::REG_SPEED_KP, pick_gain());
      write_reg(dmsp_pkg::REG_SPEED_KD, pick_gain());
      write_reg(dmsp_pkg::REG_POS_KP, pick_gain());
      write_reg(dmsp_pkg::REG_POS_KI, pick_gain());
      write_reg(dmsp_pkg::REG_POS_KD, pick_gain());
      write_reg(dmsp_pkg::REG_MAX_DRIVE,
                ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 255));
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      fault_count++;
      if (fault_count <= PRINT_CAP)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Tick driver: offer queued items, predict each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            drive_expect_q.push_back(control_tick(tick_on_bus));
            ticks_accepted <= ticks_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && tick_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               tick_on_bus = tick_queue.pop_front();
               req_valid <= 1'b1;
               req_position_a <= tick_on_bus.position_a;
               req_position_b <= tick_on_bus.position_b;
               req_elapsed_ms <= tick_on_bus.elapsed_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // sometimes back off longer so the next item lands at a random point of the work
         if (req_valid && !req_stall && $urandom_range(99) < send_idle_pct)
            gap_left <= $urandom_range(0, 160);
         else if (gap_left != 0)
            gap_left <= gap_left - 1;
      end
   end

   // Long receiver hold-offs; one forced hold fills the block while items keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && ticks_accepted >= 300) begin
         hold_left <= 700;
         long_hold_done <= 1'b1;
      end else if ($urandom_range(3999) == 0) begin
         hold_left <= $urandom_range(300, 800);
      end
   end

   always @(posedge clock) begin : drive_check
      drive_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_expect_q.size() == 0) begin
               report_mismatch("unexpected item, drive_a", 0, rsp_drive_a);
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_drive_a !== want.drive_a)
                  report_mismatch("drive_a", want.drive_a, rsp_drive_a);
               if (rsp_forward_a !== want.forward_a)
                  report_mismatch("forward_a", want.forward_a, rsp_forward_a);
               if (rsp_drive_b !== want.drive_b)
                  report_mismatch("drive_b", want.drive_b, rsp_drive_b);
               if (rsp_forward_b !== want.forward_b)
                  report_mismatch("forward_b", want.forward_b, rsp_forward_b);
               if (rsp_position_mode !== want.position_mode)
                  report_mismatch("position_mode", want.position_mode, rsp_position_mode);
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
      end
   end

   initial begin
      int p;
      int s;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 30;
      rcv_idle_pct = 62;

      // reset settings: zero time, band edges, one motor on target, counter extremes
      queue_tick(0, 0, 0);
      queue_tick(100, -100, 1);
      queue_tick(4501, 4501, 10);
      queue_tick(5499, -20000, 10);
      queue_tick(4500, 5500, 10);
      queue_tick(0, 5000, 16'hFFFF);
      queue_tick(POS_MAX, POS_MIN, 1);
      queue_tick(POS_MIN, POS_MAX, 0);
      queue_tick(5000, 5000, 1);
      queue_tick(-1, -1, 2);
      queue_tick(5010, 4990, 16'hFFFF);
      wait_idle();

      // every gain, target speed and max drive at its top end, target position at its minimum
      write_reg(dmsp_pkg::REG_TARGET_SPEED, 32'hFFFF);
      write_reg(dmsp_pkg::REG_TARGET_POSITION, POS_MIN);
      write_reg(dmsp_pkg::REG_SPEED_KP, 32'hFFFF);
      write_reg(dmsp_pkg::REG_SPEED_KD, 32'hFFFF);
      write_reg(dmsp_pkg::REG_POS_KP, 32'hFFFF);
      write_reg(dmsp_pkg::REG_POS_KI, 32'hFFFF);
      write_reg(dmsp_pkg::REG_POS_KD, 32'hFFFF);
      write_reg(dmsp_pkg::REG_MAX_DRIVE, 32'hFF);
      @(negedge clock);
      queue_tick(POS_MIN, 0, 1);
      queue_tick(POS_MAX, POS_MAX, 0);
      queue_tick(POS_MIN + 499, POS_MAX, 16'hFFFF);
      wait_idle();
      write_reg(dmsp_pkg::REG_TARGET_POSITION, POS_MAX);
      @(negedge clock);
      queue_tick(POS_MAX, POS_MIN, 1);
      queue_tick(POS_MAX - 499, POS_MIN, 3);
      wait_idle();

      // tiny gains: drive rounds to zero while direction still follows the sign
      write_reg(dmsp_pkg::REG_TARGET_SPEED, 0);
      write_reg(dmsp_pkg::REG_TARGET_POSITION, 0);
      write_reg(dmsp_pkg::REG_SPEED_KP, 1);
      write_reg(dmsp_pkg::REG_SPEED_KD, 0);
      write_reg(dmsp_pkg::REG_POS_KP, 0);
      write_reg(dmsp_pkg::REG_POS_KI, 0);
      write_reg(dmsp_pkg::REG_POS_KD, 1);
      write_reg(dmsp_pkg::REG_MAX_DRIVE, 1);
      write_reg(REG_UNMAPPED, 32'hFFFFFFFF);
      @(negedge clock);
      queue_tick(1000, -1000, 5);
      queue_tick(900, -900, 5);
      queue_tick(10, -10, 1);
      queue_tick(5000000, 0, 1);
      wait_idle();
      write_reg(dmsp_pkg::REG_MAX_DRIVE, 0);
      write_reg(dmsp_pkg::REG_SPEED_KP, 32'hFFFF);
      @(negedge clock);
      queue_tick(-5000000, 3, 7);

      for (p = 0; p < 3; p++) begin
         for (s = 0; s < 2; s++) begin
            wait_idle();
            send_idle_pct = (p == 0) ? 30 : ((p == 1) ? 62 : 0);
            rcv_idle_pct = (p == 0) ? 62 : ((p == 1) ? 30 : 0);
            randomize_settings();
            @(negedge clock);
            trk_a = target_position_q;
            trk_b = target_position_q;
            repeat (192) tick_queue.push_back(make_tick());
         end
      end

      wait_idle();
      // catch any stray item after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("dual_motor_speed_position_pid_core_tb: PASS");
      else
         $display("dual_motor_speed_position_pid_core_tb: FAIL");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("dual_motor_speed_position_pid_core_tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dmsp_pkg.sv
rtl/core/dmsp_csr.sv
rtl/core/dmsp_mul.sv
rtl/core/dmsp_div.sv
rtl/core/dual_motor_speed_position_pid_core.sv
rtl/core/dmsp_checker.sv
tb/dual_motor_speed_position_pid_core_tb.sv
